FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define LPCD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define LPCD_NEVER(lbl, clk, rstn, cond, msg) \
  `LPCD_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hdl/lpcd_pkg.sv
// Package with constants, types and state encodings of the curvature block.
`default_nettype none

package lpcd_pkg;

  localparam int CoordW    = 20;
  localparam int MaxPoints = 131072;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int WinLen    = 11;
  localparam int WinMid    = 5;
  localparam int FillW     = $clog2(WinLen + 1);
  localparam int SumW      = CoordW + 4;
  localparam int OpW       = CoordW + 5;
  localparam int MagW      = CoordW + 4;
  localparam int SqW       = 2 * MagW;
  localparam int CurvW     = 49;
  localparam int DistW     = 2 * CoordW + 3;
  localparam int RatioW    = 16;
  localparam int QuoW      = 2 * RatioW;
  localparam int RemW      = DistW + 1;
  localparam int CntW      = $clog2(QuoW);
  localparam int StepW     = 4;
  localparam int SqrSteps  = 9;
  localparam int ApbAddrW  = 2;
  localparam int ApbDataW  = 32;

  localparam logic [RatioW-1:0]   ThrReset   = 16'd512;
  localparam logic [DistW-1:0]    GateSq     = 43'd250000;
  localparam logic [ApbAddrW-1:0] RegThrAddr = 2'd0;

  typedef logic [2:0][CoordW-1:0] point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_GATE,
    S_RATIO,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT,
    R_DONE
  } rat_state_e;

  typedef struct packed {
    logic             start;
    logic [DistW-1:0] smax;
    logic [DistW-1:0] smin;
  } rat_req_t;

  typedef struct packed {
    logic              done;
    logic [RatioW-1:0] ratio;
  } rat_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/lpcd_if.sv
// Valid/ready channel interfaces for points in and curvature results out.
`default_nettype none

interface lpcd_in_if;
  import lpcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoordW-1:0] point_x;
  logic [CoordW-1:0] point_y;
  logic [CoordW-1:0] point_z;
  logic              frame_end;

  modport source (output valid, point_x, point_y, point_z, frame_end, input ready);
  modport sink   (input valid, point_x, point_y, point_z, frame_end, output ready);
endinterface

interface lpcd_out_if;
  import lpcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   center_index;
  logic [CurvW-1:0]  curvature;
  logic [RatioW-1:0] distance_ratio;
  logic              disjoint_flag;

  modport source (output valid, center_index, curvature, distance_ratio, disjoint_flag,
                  input ready);
  modport sink   (input valid, center_index, curvature, distance_ratio, disjoint_flag,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/lpcd_ratio.sv
// Q8.8 distance ratio: bit-serial divide then square root on one compare-subtract unit.
`default_nettype none
`include "assert_macros.svh"

module lpcd_ratio (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lpcd_pkg::rat_req_t req_i,
  output lpcd_pkg::rat_rsp_t     rsp_o
);
  import lpcd_pkg::*;

  rat_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [RemW-1:0]     rem_q;
  logic [QuoW-1:0]     quo_q;
  logic [RatioW-1:0]   root_q;
  logic [DistW-1:0]    div_q;
  logic [RatioW-1:0]   res_q;

  logic [RemW-1:0]     op_a, op_b;
  logic [RemW:0]       diff;
  logic                ge;
  logic                last;
  logic                sat;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      R_DIV: begin
        op_a = {rem_q[RemW-2:0], quo_q[QuoW-1]};
        op_b = {1'b0, div_q};
      end
      R_SQRT: begin
        op_a = {rem_q[RemW-3:0], quo_q[QuoW-1:QuoW-2]};
        op_b = RemW'({root_q, 2'b01});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[RemW];
  end

  assign last = (cnt_q == '0);
  assign sat  = ({{RatioW{1'b0}}, req_i.smax} >= {req_i.smin, {RatioW{1'b0}}});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          state_d = sat ? R_DONE : R_DIV;
          cnt_d   = CntW'(QuoW - 1);
        end
      end
      R_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (last) begin
          state_d = R_SQRT;
          cnt_d   = CntW'(RatioW - 1);
        end
      end
      R_SQRT: begin
        cnt_d = cnt_q - 1'b1;
        if (last) begin
          state_d = R_DONE;
        end
      end
      R_DONE: begin
        state_d = R_IDLE;
      end
      default: begin
        state_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          div_q <= req_i.smin;
          rem_q <= RemW'(req_i.smax >> RatioW);
          quo_q <= {req_i.smax[RatioW-1:0], {RatioW{1'b0}}};
          res_q <= '1;
        end
      end
      R_DIV: begin
        quo_q <= {quo_q[QuoW-2:0], ge};
        if (last) begin
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          rem_q <= ge ? diff[RemW-1:0] : op_a;
        end
      end
      R_SQRT: begin
        rem_q  <= ge ? diff[RemW-1:0] : op_a;
        quo_q  <= {quo_q[QuoW-3:0], 2'b00};
        root_q <= {root_q[RatioW-2:0], ge};
        if (last) begin
          res_q <= {root_q[RatioW-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.done  = (state_q == R_DONE);
  assign rsp_o.ratio = res_q;

  `LPCD_ASSERT(a_start_when_idle, clk_i, rst_ni, req_i.start |-> state_q == R_IDLE, "ratio start while busy")
  `LPCD_ASSERT(a_div_rem_bound, clk_i, rst_ni, (state_q == R_DIV) |-> (rem_q < {1'b0, div_q}), "division remainder not below divisor")
  `LPCD_ASSERT(a_sqrt_rem_bound, clk_i, rst_ni, (state_q == R_SQRT) |-> (rem_q <= RemW'({root_q, 1'b0})), "root remainder above twice the root")

endmodule

`default_nettype wire

FILE: hdl/lidar_point_curvature_disjoint.sv
// Top level: 11-point window, shared squarer for curvature and distances, APB threshold.
`default_nettype none
`include "assert_macros.svh"

// Points enter one at a time while in_ch_i.ready is high. The first ten points of a
// frame only fill the window and are taken back to back. From the eleventh on, each
// point yields one result for the point five places back: it is accepted, then runs
// through the single squarer (three curvature terms, six distance terms, one drain),
// the gate and the output step. When the larger neighbor gap is at most 500 mm the
// ratio unit is skipped; if the ratio saturates it goes straight to its done state.
// Otherwise it works out 32 quotient bits then 16 root bits, one per cycle on one
// compare-subtract, before its done state. The output step repeats while the output
// register still holds an earlier result that out_ch_o.ready has not taken. A finished
// result waits in the output register while the next point is taken. A frame_end point
// clears the window and position counter after its result, or at once if it has none.
module lidar_point_curvature_disjoint (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lpcd_in_if.sink                              in_ch_i,
  lpcd_out_if.source                           out_ch_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [lpcd_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [lpcd_pkg::ApbDataW-1:0]   pwdata,
  output logic      [lpcd_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready
);
  import lpcd_pkg::*;

  state_e                   state_q, state_d;
  logic [RatioW-1:0]        thr_q;
  point_t                   win_q [WinLen];
  logic signed [SumW-1:0]   sum_q [3];
  logic [FillW-1:0]         fill_q;
  logic [IdxW-1:0]          cnt_q;
  logic [IdxW-1:0]          cidx_q;
  logic                     fe_q;
  logic [StepW-1:0]         step_q;
  logic [SqW-1:0]           prod_q;
  logic [CurvW-1:0]         curv_q;
  logic [DistW-1:0]         sf_q, sb_q;
  logic [RatioW-1:0]        ratio_q;
  logic                     out_valid_q;
  logic [IdxW-1:0]          out_idx_q;
  logic [CurvW-1:0]         out_curv_q;
  logic [RatioW-1:0]        out_ratio_q;
  logic                     out_flag_q;

  logic                     acc;
  logic                     produce;
  logic                     out_load;
  logic                     clr;
  logic                     sqr_done;
  point_t                   new_pt;
  logic [1:0]               ax;
  logic signed [OpW-1:0]    cen_x, cen11, opnd;
  logic [MagW-1:0]          mag;
  logic [DistW-1:0]         smax, smin;
  logic                     gate_ok;
  rat_req_t                 rat_req;
  rat_rsp_t                 rat_rsp;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == RegThrAddr) ? ApbDataW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (psel && penable && pwrite && pready && (paddr == RegThrAddr)) begin
      thr_q <= pwdata[RatioW-1:0];
    end
  end

  // sequencer
  assign acc      = in_ch_i.valid && in_ch_i.ready;
  assign produce  = (fill_q >= FillW'(WinLen - 1));
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch_o.ready);
  assign clr      = (out_load && fe_q) || (acc && !produce && in_ch_i.frame_end);
  assign sqr_done = (step_q == StepW'(SqrSteps));

  assign smax    = (sf_q > sb_q) ? sf_q : sb_q;
  assign smin    = (sf_q > sb_q) ? sb_q : sf_q;
  assign gate_ok = (smax > GateSq);

  always_comb begin
    state_d        = state_q;
    in_ch_i.ready  = 1'b0;
    rat_req.start  = 1'b0;
    rat_req.smax   = smax;
    rat_req.smin   = smin;
    case (state_q)
      S_IDLE: begin
        in_ch_i.ready = 1'b1;
        if (in_ch_i.valid && produce) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (sqr_done) begin
          state_d = S_GATE;
        end
      end
      S_GATE: begin
        if (gate_ok) begin
          rat_req.start = 1'b1;
          state_d       = S_RATIO;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RATIO: begin
        if (rat_rsp.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      fe_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc) begin
        step_q <= '0;
        fe_q   <= in_ch_i.frame_end;
      end else if (state_q == S_SQR && !sqr_done) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // window, running sums, fill and position
  assign new_pt[0] = in_ch_i.point_x;
  assign new_pt[1] = in_ch_i.point_y;
  assign new_pt[2] = in_ch_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
      end
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (clr) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= '0;
      end
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (acc) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinLen-1] <= new_pt;
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= sum_q[a] + SumW'($signed(new_pt[a])) - SumW'($signed(win_q[0][a]));
      end
      if (fill_q != FillW'(WinLen)) begin
        fill_q <= fill_q + 1'b1;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // shared squarer operand
  always_comb begin
    case (step_q) inside
      4'd0, 4'd3, 4'd6: ax = 2'd0;
      4'd1, 4'd4, 4'd7: ax = 2'd1;
      default:          ax = 2'd2;
    endcase
    cen_x = OpW'($signed(win_q[WinMid][ax]));
    cen11 = (cen_x <<< 3) + (cen_x <<< 1) + cen_x;
    case (step_q) inside
      [4'd0:4'd2]: opnd = OpW'(sum_q[ax]) - cen11;
      [4'd3:4'd5]: opnd = OpW'($signed(win_q[WinMid-1][ax])) - cen_x;
      default:     opnd = OpW'($signed(win_q[WinMid+1][ax])) - cen_x;
    endcase
    mag = opnd[OpW-1] ? MagW'(-opnd) : MagW'(opnd);
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      curv_q <= '0;
      sf_q   <= '0;
      sb_q   <= '0;
      cidx_q <= cnt_q - IdxW'(WinMid);
    end else if (state_q == S_SQR) begin
      if (!sqr_done) begin
        prod_q <= mag * mag;
      end
      case (step_q) inside
        [4'd1:4'd3]: curv_q <= curv_q + CurvW'(prod_q);
        [4'd4:4'd6]: sf_q   <= sf_q + prod_q[DistW-1:0];
        [4'd7:4'd9]: sb_q   <= sb_q + prod_q[DistW-1:0];
        default: begin
        end
      endcase
    end
    if (state_q == S_GATE && !gate_ok) begin
      ratio_q <= '0;
    end else if (state_q == S_RATIO && rat_rsp.done) begin
      ratio_q <= rat_rsp.ratio;
    end
  end

  lpcd_ratio u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rat_req),
    .rsp_o  (rat_rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q   <= cidx_q;
      out_curv_q  <= curv_q;
      out_ratio_q <= ratio_q;
      out_flag_q  <= (ratio_q > thr_q);
    end
  end

  assign out_ch_o.valid          = out_valid_q;
  assign out_ch_o.center_index   = out_idx_q;
  assign out_ch_o.curvature      = out_curv_q;
  assign out_ch_o.distance_ratio = out_ratio_q;
  assign out_ch_o.disjoint_flag  = out_flag_q;

  `LPCD_ASSERT(a_out_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == S_DONE),
    "result shown without finished computation")
  `LPCD_ASSERT(a_full_window_busy, clk_i, rst_ni,
    (acc && produce) |=> (state_q == S_SQR && !in_ch_i.ready),
    "full window did not start computation")
  `LPCD_NEVER(a_frame_clear, clk_i, rst_ni,
    $past(out_load && fe_q) && (fill_q != '0 || cnt_q != '0),
    "frame end did not clear window")

endmodule

`default_nettype wire
